// ===== hw/rtl/srta_pkg.sv =====
// ----------------------------------------------------------------------------
// srta_pkg: shared types and constants for the signed radix to ASCII block
// Transaction payloads, character codes, radix limits and digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package srta_pkg;

  localparam int VALUE_W        = 32;
  localparam int RADIX_W        = 6;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CH_ZERO   = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CH_NINE   = CHAR_W'(8'h39);
  localparam logic [CHAR_W-1:0] ALPHA_GAP = CHAR_W'(7);
  localparam logic [CHAR_W-1:0] CH_MINUS  = CHAR_W'(8'h2D);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [RADIX_W-1:0]        radix;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // Digits above nine skip the punctuation between '9' and 'A'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d) + CH_ZERO;
    if (c > CH_NINE) begin
      c = c + ALPHA_GAP;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srta_ram.sv =====
// ----------------------------------------------------------------------------
// srta_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/srta_div.sv =====
// ----------------------------------------------------------------------------
// srta_div: restoring divider, one quotient bit per cycle
// Divides an unsigned value by a small radix; pulses done when finished.
// ----------------------------------------------------------------------------
`default_nettype none

module srta_div #(
  parameter int VALUE_BITS = srta_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [VALUE_BITS-1:0]         dividend,
  input  wire logic [srta_pkg::RADIX_W-1:0]  divisor,
  output logic                               done,
  output logic      [VALUE_BITS-1:0]         quotient,
  output logic      [srta_pkg::DIGIT_W-1:0]  remainder
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]         q_r, q_nxt;
  logic [srta_pkg::DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [srta_pkg::RADIX_W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [srta_pkg::DIGIT_W:0]    trial;
  logic [srta_pkg::DIGIT_W:0]    diff;

  assign trial = {rem_r, q_r[VALUE_BITS-1]};
  assign diff  = trial - (srta_pkg::DIGIT_W + 1)'(dsr_r);

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract where the trial remainder covers the divisor, else restore
      if (trial >= (srta_pkg::DIGIT_W + 1)'(dsr_r)) begin
        rem_nxt = diff[srta_pkg::DIGIT_W-1:0];
        q_nxt   = {q_r[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[srta_pkg::DIGIT_W-1:0];
        q_nxt   = {q_r[VALUE_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_radix_to_ascii.sv =====
// Flow: one division per digit, then a sign in S_SIGN if negative and each
// digit through S_RD, S_LOAD and S_EMIT; out_stall holds S_SIGN and S_EMIT.
// One transaction at a time (in_stall is high outside S_IDLE); the single
// one-bit-per-cycle divider is reused for every digit.
// Reset: synchronous, active low; sequencer and divider return to idle,
// the digit store is not cleared.
// ----------------------------------------------------------------------------
// signed_radix_to_ascii: signed integer to ASCII text in radix 2..36
// Divides repeatedly by the radix, stores the digits, then emits sign and
// digits most significant first with the last character marked.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix_to_ascii #(
  parameter int VALUE_BITS = srta_pkg::VALUE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire srta_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output srta_pkg::out_t      out_data
);

  localparam int AW       = $clog2(VALUE_BITS);
  localparam int CW       = $clog2(VALUE_BITS + 1);
  localparam int EXT_BITS = (VALUE_BITS > srta_pkg::VALUE_W) ? VALUE_BITS : srta_pkg::VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_RD,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          neg_r, neg_nxt;
  logic [srta_pkg::RADIX_W-1:0]  radix_r, radix_nxt;
  logic                          out_valid_r, out_valid_nxt;
  srta_pkg::out_t                out_data_r, out_data_nxt;

  logic [EXT_BITS-1:0]           val_ext;
  logic [VALUE_BITS-1:0]         val;
  logic [VALUE_BITS-1:0]         mag;
  logic [srta_pkg::RADIX_W-1:0]  radix_in;

  logic                          div_start;
  logic [VALUE_BITS-1:0]         div_dividend;
  logic [srta_pkg::RADIX_W-1:0]  div_divisor;
  logic                          div_done;
  logic [VALUE_BITS-1:0]         div_quot;
  logic [srta_pkg::DIGIT_W-1:0]  div_rem;

  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [srta_pkg::DIGIT_W-1:0]  ram_rdata;
  logic [CW-1:0]                 cnt_dec;

  logic                          in_acc;

  assign val_ext  = EXT_BITS'(in_data.value);
  assign val      = val_ext[VALUE_BITS-1:0];
  assign mag      = val[VALUE_BITS-1] ? (~val + VALUE_BITS'(1)) : val;
  assign radix_in = srta_pkg::clamp_radix(in_data.radix);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);

  assign cnt_dec   = cnt_r - CW'(1);
  assign ram_raddr = cnt_dec[AW-1:0];
  assign ram_we    = (state_r == S_DIV) && div_done;

  // keep dividing while the quotient is non-zero
  assign div_start    = in_acc || ((state_r == S_DIV) && div_done && (div_quot != '0));
  assign div_dividend = (state_r == S_IDLE) ? mag : div_quot;
  assign div_divisor  = (state_r == S_IDLE) ? radix_in : radix_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    radix_nxt     = radix_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt   = val[VALUE_BITS-1];
          radix_nxt = radix_in;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          cnt_nxt = cnt_r + CW'(1);
          if (div_quot == '0) begin
            if (neg_r) begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.character = srta_pkg::CH_MINUS;
              out_data_nxt.last      = 1'b0;
              state_nxt              = S_SIGN;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_SIGN: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.character = srta_pkg::digit_char(ram_rdata);
        out_data_nxt.last      = (cnt_r == CW'(1));
        cnt_nxt                = cnt_dec;
        state_nxt              = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = (cnt_r == '0) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    radix_r    <= radix_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  srta_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  srta_ram #(
    .WIDTH(srta_pkg::DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[AW-1:0]),
    .wdata(div_rem),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/srta_chk.sv =====
// ----------------------------------------------------------------------------
// srta_chk: port-level checks for signed_radix_to_ascii
// Watches both transaction channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module srta_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire srta_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire srta_pkg::out_t out_data
);

  // an offered value carries known bits
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_data))
    else $error("unknown payload offered with valid");

  // no new transaction is taken while a character is on offer
  a_busy_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a character is pending");

  // an accepted value occupies the block on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block free straight after accepting a value");

  // a sign never ends the text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.character == srta_pkg::CH_MINUS)) |-> !out_data.last)
    else $error("minus sign marked as last character");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output changed");

endmodule

bind signed_radix_to_ascii srta_chk u_srta_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

// ===== dv/signed_radix_to_ascii_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_to_ascii_test: self-checking bench for the radix to ASCII block
// Sends directed and random signed values with in-range and clamped radices.
// A scoreboard predicts each value's text and checks every character and its
// last flag in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module signed_radix_to_ascii_test;
  import srta_pkg::*;

  localparam int              N_RANDOM    = 250;
  localparam int              STUCK_LIMIT = 8000;
  localparam int              DRAIN_CYCLES = 40;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = CHAR_W'(8'h41);

  class text_scoreboard;
    out_t pending_chars[$];
    int   errors;
    int   values_seen;
    int   negatives_seen;
    int   clamped_seen;
    int   chars_checked;

    function new();
      errors = 0;
      values_seen = 0;
      negatives_seen = 0;
      clamped_seen = 0;
      chars_checked = 0;
    endfunction

    // Work out the full text of one value and queue its characters.
    function void note_value(in_t item);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digits[$];
      int                 base;
      logic [DIGIT_W-1:0] d;
      out_t               ch;
      values_seen++;
      if (item.radix < 2) begin
        base = 2;
      end else if (item.radix > 36) begin
        base = 36;
      end else begin
        base = item.radix;
      end
      if (base != item.radix) clamped_seen++;
      mag = item.value[VALUE_W-1] ? -item.value : item.value;
      do begin
        digits.push_back(DIGIT_W'(mag % base));
        mag = mag / base;
      end while (mag != 0);
      if (item.value[VALUE_W-1]) begin
        negatives_seen++;
        ch.character = CH_MINUS;
        ch.last = 1'b0;
        pending_chars.push_back(ch);
      end
      while (digits.size() > 0) begin
        d = digits.pop_back();
        ch.character = (d < 10) ? CH_ZERO + CHAR_W'(d) : CH_UPPER_A + CHAR_W'(d - 10);
        ch.last = (digits.size() == 0);
        pending_chars.push_back(ch);
      end
    endfunction

    function void check_char(out_t got);
      out_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, got.character, got.last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (got.character !== want.character) begin
        $display("%0t: character mismatch: expected %h, actual %h",
                 $time, want.character, got.character);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic steady;
  int   stuck_cycles = 0;

  text_scoreboard sb = new();

  signed_radix_to_ascii dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_value(in_data);
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check_char(out_data);
    end
    if (rst_n && ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 36);
    end
  end

  // Hold valid and payload until the block takes the transaction.
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.value = v;
    in_data.radix = r;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [VALUE_W-1:0] v;
    logic [RADIX_W-1:0] r;
    int                 k;
    in_valid = 1'b0;
    in_data = '0;
    steady = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero, sign extremes, radix clamping, letter digits.
    send_value(32'd0, 6'd10);
    send_value(32'h7FFF_FFFF, 6'd10);
    send_value(32'h8000_0000, 6'd10);
    send_value(32'hFFFF_FFFF, 6'd10);
    send_value(32'd1, 6'd2);
    send_value(32'h8000_0000, 6'd2);
    send_value(32'h7FFF_FFFF, 6'd2);
    send_value(32'hFFFF_FFFF, 6'd16);
    send_value(32'd5, 6'd0);
    send_value(32'd6, 6'd1);
    send_value(32'd1295, 6'd63);
    send_value(32'd35, 6'd37);
    send_value(32'd35, 6'd36);
    send_value(32'h7FFF_FFFF, 6'd36);
    send_value(32'h8000_0000, 6'd36);
    send_value(32'hDEAD_BEEF, 6'd16);
    send_value(32'd511, 6'd8);
    send_value(32'd9, 6'd10);
    send_value(32'd10, 6'd11);
    send_value(32'd0, 6'd0);
    send_value(32'd0, 6'd63);
    send_value(-32'sd100, 6'd3);
    send_value(32'd36, 6'd36);
    send_value(-32'sd1, 6'd63);

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 120 && i < 170);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = $urandom;
        4, 5: v = $urandom_range(0, 200) - 100;
        6: begin
          k = $urandom_range(0, 31);
          v = (32'd1 << k) - $urandom_range(0, 1);
          if ($urandom_range(0, 1)) v = -v;
        end
        7: begin
          case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'd0;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        default: begin
          v = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1)) v = -v;
        end
      endcase
      r = ($urandom_range(0, 4) == 0) ? RADIX_W'($urandom_range(0, 63))
                                       : RADIX_W'($urandom_range(2, 36));
      send_value(v, r);
    end
    steady = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d negative, %0d with radix clamped),",
             sb.values_seen, sb.negatives_seen, sb.clamped_seen);
    $display("%0d characters checked.", sb.chars_checked);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
